// File: sv/rts_pkg.sv
`default_nettype none

package rts_pkg;

	localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
	localparam logic [26:0] MS_PER_MIN  = 27'd60000;
	localparam logic [26:0] MS_PER_SEC  = 27'd1000;

	// reciprocal estimates, floor(2^RECIP_SHIFT / divisor), low by at most one
	localparam int unsigned RECIP_SHIFT = 32;
	localparam logic [31:0] RECIP_HOUR = 32'((64'd1 << RECIP_SHIFT) / 64'(MS_PER_HOUR));
	localparam logic [31:0] RECIP_MIN  = 32'((64'd1 << RECIP_SHIFT) / 64'(MS_PER_MIN));
	localparam logic [31:0] RECIP_SEC  = 32'((64'd1 << RECIP_SHIFT) / 64'(MS_PER_SEC));

	// whole hours, minutes and seconds in a 27-bit millisecond count
	localparam int unsigned HQ_W = 6;
	localparam int unsigned MQ_W = 12;
	localparam int unsigned SQ_W = 18;

	localparam logic [5:0] HOUR_LIMIT = 6'd24;
	localparam logic [5:0] HOUR_TOP   = 6'd23;
	localparam logic [5:0] MIN_LIMIT  = 6'd60;
	localparam logic [5:0] MIN_TOP    = 6'd59;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TURN  = 1'b1;

	localparam logic [1:0] FIELD_HOURS   = 2'd0;
	localparam logic [1:0] FIELD_MINUTES = 2'd1;
	localparam logic [1:0] FIELD_SECONDS = 2'd2;
	localparam logic [1:0] FIELD_NONE    = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [26:0] start_ms;
		logic        turn_left;
		logic        turn_right;
		logic        press;
	} item_t;

	typedef struct packed {
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic        show_hours;
		logic        show_minutes;
		logic        show_seconds;
		logic [1:0]  field_selected;
		logic        beep_short;
		logic        beep_long;
		logic        done_res;
		logic [26:0] new_time_ms;
	} result_t;

	// request after splitting: exact quotients of start_ms by hour, minute, second
	typedef struct packed {
		logic            mode;
		logic            turn_left;
		logic            turn_right;
		logic            press;
		logic [HQ_W-1:0] hq;
		logic [MQ_W-1:0] mq;
		logic [SQ_W-1:0] sq;
	} split_t;

endpackage

`default_nettype wire

// File: sv/rotary_time_setter.sv
// time-of-day set controller for a rotary encoder with push button
// request channel: item_valid / item_stall / item. mode 0 loads start_ms and
// opens editing on the hours field; mode 1 carries the turn and press flags of
// one encoder wait period and edits the selected field (blink, wrap, advance).
// result channel: result_valid / result_stall / result. every request gives
// exactly one result: the held values, show flags, selected field, beep
// requests, and on the final press of the seconds field done_res with the
// new millisecond-of-day value (0 otherwise).
// a request passes through an input register, a reciprocal-multiply estimate,
// a remainder correction, the edit step, and the output register that builds
// new_time_ms. one request per cycle is taken sustained while result_stall
// stays low; the edit state is the only loop and it updates on each request.
// a stalled result holds in the output register; empty stages still take new
// requests, and item_stall rises only once every stage is full.
// reset clears all valids and returns to idle with time 00:00:00, hours
// selected and all fields shown.
`default_nettype none

module rotary_time_setter (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire rts_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rts_pkg::result_t      result
);
	import rts_pkg::*;

	logic    item_ready;
	logic    split_valid, split_ready;
	split_t  split;
	logic    view_valid, view_ready;
	result_t view;

	assign item_stall = !item_ready;

	rts_divide u_divide (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.split       (split)
	);

	rts_edit u_edit (
		.clk         (clk),
		.arst_n      (arst_n),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.split       (split),
		.view_valid  (view_valid),
		.view_ready  (view_ready),
		.view        (view)
	);

	rts_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.view_valid   (view_valid),
		.view_ready   (view_ready),
		.view         (view),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// File: sv/rts_divide.sv
`default_nettype none

module rts_divide (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire rts_pkg::item_t item,
	output logic                split_valid,
	input  wire logic           split_ready,
	output rts_pkg::split_t     split
);
	import rts_pkg::*;

	logic            v_s1, v_s2, v_s3;
	logic            ready2, ready3;
	item_t           item_s1, item_s2;
	logic [HQ_W-1:0] hest_s2;
	logic [MQ_W-1:0] mest_s2;
	logic [SQ_W-1:0] sest_s2;
	split_t          split_s3;

	logic [58:0]     hprod, mprod, sprod;
	logic [26:0]     hrem, mrem, srem;

	assign ready3     = !v_s3 || split_ready;
	assign ready2     = !v_s2 || ready3;
	assign item_ready = !v_s1 || ready2;

	assign hprod = 59'(item_s1.start_ms) * 59'(RECIP_HOUR);
	assign mprod = 59'(item_s1.start_ms) * 59'(RECIP_MIN);
	assign sprod = 59'(item_s1.start_ms) * 59'(RECIP_SEC);

	// estimate never exceeds the true quotient, so the remainder stays below twice the divisor
	assign hrem = item_s2.start_ms - 27'(hest_s2) * MS_PER_HOUR;
	assign mrem = item_s2.start_ms - 27'(mest_s2) * MS_PER_MIN;
	assign srem = item_s2.start_ms - 27'(sest_s2) * MS_PER_SEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (item_ready) begin
				v_s1 <= item_valid;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (ready3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (ready2 && v_s1) begin
			item_s2 <= item_s1;
			hest_s2 <= hprod[RECIP_SHIFT +: HQ_W];
			mest_s2 <= mprod[RECIP_SHIFT +: MQ_W];
			sest_s2 <= sprod[RECIP_SHIFT +: SQ_W];
		end
		if (ready3 && v_s2) begin
			split_s3.mode       <= item_s2.mode;
			split_s3.turn_left  <= item_s2.turn_left;
			split_s3.turn_right <= item_s2.turn_right;
			split_s3.press      <= item_s2.press;
			split_s3.hq <= hest_s2 + HQ_W'(hrem >= MS_PER_HOUR);
			split_s3.mq <= mest_s2 + MQ_W'(mrem >= MS_PER_MIN);
			split_s3.sq <= sest_s2 + SQ_W'(srem >= MS_PER_SEC);
		end
	end

	assign split_valid = v_s3;
	assign split       = split_s3;

endmodule

`default_nettype wire

// File: sv/rts_edit.sv
`default_nettype none

module rts_edit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            split_valid,
	output logic                 split_ready,
	input  wire rts_pkg::split_t split,
	output logic                 view_valid,
	input  wire logic            view_ready,
	output rts_pkg::result_t     view
);
	import rts_pkg::*;

	function automatic logic [5:0] turn_value(input logic [5:0] v, input logic [5:0] top,
		input logic l, input logic r);
		logic [5:0] res;
		res = v;
		if (l && !r) begin
			res = (v == 6'd0) ? top : v - 6'd1;
		end else if (r && !l) begin
			res = (v >= top) ? 6'd0 : v + 6'd1;
		end
		return res;
	endfunction

	logic       editing_q;
	logic [1:0] field_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q, second_q;
	logic [2:0] vis_q;

	logic       editing_n;
	logic [1:0] field_n;
	logic [4:0] hour_n;
	logic [5:0] minute_n, second_n;
	logic [2:0] vis_n;
	logic       beep_s, beep_l, done_n;

	logic       take;
	logic       v_s4;
	result_t    view_s4;

	logic [4:0] start_hour;
	logic [5:0] start_min, start_sec;
	logic [2:0] mask;
	logic [5:0] cur, top, turned;

	assign split_ready = !v_s4 || view_ready;
	assign take        = split_valid && split_ready;

	assign start_hour = ({1'b0, split.hq} >= {1'b0, HOUR_LIMIT}) ? 5'd0 : 5'(split.hq);
	assign start_min  = 6'(split.mq - 12'(split.hq) * 12'(MIN_LIMIT));
	assign start_sec  = 6'(split.sq - 18'(split.mq) * 18'(MIN_LIMIT));

	assign mask = 3'b001 << field_q;

	always_comb begin
		unique case (field_q)
			FIELD_HOURS: begin
				cur = {1'b0, hour_q};
				top = HOUR_TOP;
			end
			FIELD_MINUTES: begin
				cur = minute_q;
				top = MIN_TOP;
			end
			FIELD_SECONDS: begin
				cur = second_q;
				top = MIN_TOP;
			end
			FIELD_NONE: begin
				cur = 6'd0;
				top = MIN_TOP;
			end
		endcase
	end

	assign turned = turn_value(cur, top, split.turn_left, split.turn_right);

	always_comb begin
		editing_n = editing_q;
		field_n   = field_q;
		hour_n    = hour_q;
		minute_n  = minute_q;
		second_n  = second_q;
		vis_n     = vis_q;
		beep_s    = 1'b0;
		beep_l    = 1'b0;
		done_n    = 1'b0;
		if (split.mode == MODE_START) begin
			hour_n    = start_hour;
			minute_n  = start_min;
			second_n  = start_sec;
			field_n   = FIELD_HOURS;
			vis_n     = 3'b111;
			editing_n = 1'b1;
		end else if (editing_q && field_q != FIELD_NONE) begin
			// blink the selected field, a turn or a press on hours or minutes forces it back on
			vis_n = vis_q ^ mask;
			if (split.turn_left || split.turn_right) begin
				beep_s = 1'b1;
				vis_n  = vis_n | mask;
				unique case (field_q)
					FIELD_HOURS:   hour_n   = turned[4:0];
					FIELD_MINUTES: minute_n = turned;
					FIELD_SECONDS: second_n = turned;
					FIELD_NONE:    second_n = second_q;
				endcase
			end
			if (split.press) begin
				beep_l = 1'b1;
				if (field_q != FIELD_SECONDS) begin
					vis_n   = vis_n | mask;
					field_n = field_q + 2'd1;
				end else begin
					done_n    = 1'b1;
					editing_n = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			editing_q <= 1'b0;
			field_q   <= FIELD_HOURS;
			hour_q    <= 5'd0;
			minute_q  <= 6'd0;
			second_q  <= 6'd0;
			vis_q     <= 3'b111;
			v_s4      <= 1'b0;
		end else begin
			if (split_ready) begin
				v_s4 <= split_valid;
			end
			if (take) begin
				editing_q <= editing_n;
				field_q   <= field_n;
				hour_q    <= hour_n;
				minute_q  <= minute_n;
				second_q  <= second_n;
				vis_q     <= vis_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			view_s4.hours          <= hour_n;
			view_s4.minutes        <= minute_n;
			view_s4.seconds        <= second_n;
			view_s4.show_hours     <= vis_n[0];
			view_s4.show_minutes   <= vis_n[1];
			view_s4.show_seconds   <= vis_n[2];
			view_s4.field_selected <= field_n;
			view_s4.beep_short     <= beep_s;
			view_s4.beep_long      <= beep_l;
			view_s4.done_res       <= done_n;
			// filled in by the output stage
			view_s4.new_time_ms    <= 27'd0;
		end
	end

	assign view_valid = v_s4;
	assign view       = view_s4;

`ifndef ASSERT_OFF
	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		take && split.mode == MODE_START |=>
			editing_q && field_q == FIELD_HOURS && vis_q == 3'b111)
		else $error("start request did not open editing on hours");

	a_values_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, hour_q} < HOUR_LIMIT && minute_q < MIN_LIMIT && second_q < MIN_LIMIT)
		else $error("held time value out of range");

	a_done_ends_edit: assert property (@(posedge clk) disable iff (!arst_n)
		take && done_n |=> !editing_q && field_q == FIELD_SECONDS)
		else $error("editing still open after done");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(editing_q) && $stable(field_q) && $stable(hour_q) && $stable(vis_q))
		else $error("edit state changed without a request");

	a_done_with_press: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && view_s4.done_res |-> view_s4.beep_long && view_s4.field_selected == FIELD_SECONDS)
		else $error("done result without a press on seconds");
`endif

endmodule

`default_nettype wire

// File: sv/rts_pack.sv
`default_nettype none

module rts_pack (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             view_valid,
	output logic                  view_ready,
	input  wire rts_pkg::result_t view,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rts_pkg::result_t      result
);
	import rts_pkg::*;

	logic        v_q;
	result_t     res_q;
	result_t     res_d;
	logic [26:0] total_ms;

	assign view_ready = !v_q || !result_stall;

	assign total_ms = 27'(view.hours) * MS_PER_HOUR + 27'(view.minutes) * MS_PER_MIN
		+ 27'(view.seconds) * MS_PER_SEC;

	always_comb begin
		res_d             = view;
		res_d.new_time_ms = view.done_res ? total_ms : 27'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (view_ready) begin
			v_q <= view_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (view_ready && view_valid) begin
			res_q <= res_d;
		end
	end

	assign result_valid = v_q;
	assign result       = res_q;

endmodule

`default_nettype wire
